@@ rtl/core/ovc_pkg.sv @@
// Shared constants, types and state codes of the oversampled ADC reference corrector.
package ovc_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int CNT_BITS     = 16;
  localparam int VCAL_BITS    = 12;
  localparam int OUT_BITS     = 16;
  localparam int SUM_BITS     = SAMPLE_BITS + CNT_BITS;
  localparam int PROD_BITS    = SUM_BITS + VCAL_BITS;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int JOB_DEPTH    = 2;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_BITS = $clog2(JOB_DEPTH + 1);
  localparam int STEP_BITS    = $clog2(SUM_BITS);

  localparam logic [CNT_BITS-1:0]  OVS_RESET  = CNT_BITS'(1);
  localparam logic [VCAL_BITS-1:0] VCAL_RESET = VCAL_BITS'(1489);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OVERSAMPLE = 1'b0,
    REG_VREF_CAL   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  target_sum;
    logic [SUM_BITS-1:0]  ref_sum;
    logic [CNT_BITS-1:0]  n;
    logic [VCAL_BITS-1:0] vcal;
  } job_t;

  typedef struct packed {
    logic avail;
    job_t job;
  } job_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

@@ rtl/core/ovc_front.sv @@
// Front end: accumulates sample pairs and issues one job per completed block.
module ovc_front import ovc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] target_sample,
  input  logic [SAMPLE_BITS-1:0] vref_sample,
  input  logic [CNT_BITS-1:0]    oversample_count,
  input  logic [VCAL_BITS-1:0]   vref_cal,
  input  logic                   job_full,
  output logic                   job_push,
  output job_t                   job_wdata
);

  logic [SUM_BITS-1:0] target_sum_r, target_sum_nxt;
  logic [SUM_BITS-1:0] ref_sum_r, ref_sum_nxt;
  logic [CNT_BITS-1:0] pair_count_r, pair_count_nxt;
  logic [SUM_BITS-1:0] t_add, r_add;
  logic [CNT_BITS-1:0] cnt_inc, n_eff;
  logic                accept, last;

  assign full    = job_full;
  assign accept  = push && !job_full;
  assign n_eff   = (oversample_count == '0) ? CNT_BITS'(1) : oversample_count;
  assign cnt_inc = pair_count_r + CNT_BITS'(1);
  assign last    = !(cnt_inc < n_eff);
  assign t_add   = target_sum_r + SUM_BITS'(target_sample);
  assign r_add   = ref_sum_r + SUM_BITS'(vref_sample);

  assign job_push             = accept && last;
  assign job_wdata.target_sum = t_add;
  assign job_wdata.ref_sum    = r_add;
  assign job_wdata.n          = n_eff;
  assign job_wdata.vcal       = vref_cal;

  always_comb begin
    target_sum_nxt = target_sum_r;
    ref_sum_nxt    = ref_sum_r;
    pair_count_nxt = pair_count_r;
    if (accept) begin
      if (last) begin
        target_sum_nxt = '0;
        ref_sum_nxt    = '0;
        pair_count_nxt = '0;
      end else begin
        target_sum_nxt = t_add;
        ref_sum_nxt    = r_add;
        pair_count_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_sum_r <= '0;
      ref_sum_r    <= '0;
      pair_count_r <= '0;
    end else begin
      target_sum_r <= target_sum_nxt;
      ref_sum_r    <= ref_sum_nxt;
      pair_count_r <= pair_count_nxt;
    end
  end

endmodule

@@ rtl/core/ovc_job_fifo.sv @@
// Short job queue between the accumulating front end and the arithmetic back end.
module ovc_job_fifo import ovc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  job_t    wr_data,
  output logic    wr_full,
  input  logic    rd_en,
  output job_rd_t rd
);

  job_t                    mem_r [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [JOB_PTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [JOB_CNT_BITS-1:0] count_r, count_nxt;
  logic                    do_wr, do_rd;

  assign wr_full  = (count_r == JOB_CNT_BITS'(JOB_DEPTH));
  assign rd.avail = (count_r != '0);
  assign rd.job   = mem_r[rptr_r];
  assign do_wr    = wr_en && !wr_full;
  assign do_rd    = rd_en && rd.avail;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == JOB_PTR_BITS'(JOB_DEPTH - 1)) ? '0 : wptr_r + JOB_PTR_BITS'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == JOB_PTR_BITS'(JOB_DEPTH - 1)) ? '0 : rptr_r + JOB_PTR_BITS'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + JOB_CNT_BITS'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - JOB_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/core/ovc_back.sv @@
// Back end: bit-serial averaging, calibration multiply, corrected division and result word.
module ovc_back import ovc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  job_rd_t              job,
  output logic                 job_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [OUT_BITS-1:0]  corrected_value,
  output logic                 saturated,
  output logic                 ref_zero_error
);

  back_state_t state_r, state_nxt;

  logic [STEP_BITS-1:0] step_r;
  logic [SUM_BITS-1:0]  tq_r, rq_r;
  logic [CNT_BITS-1:0]  trem_r, rrem_r, n_r;
  logic [VCAL_BITS-1:0] vcal_r;
  logic [PROD_BITS-1:0] prod_r;
  logic [SUM_BITS-1:0]  qrem_r;
  logic [OUT_BITS-1:0]  qq_r;
  logic [OUT_BITS-1:0]  res_val_r;
  logic                 res_sat_r, res_err_r;
  logic                 out_valid_r;
  logic [OUT_BITS-1:0]  out_val_r;
  logic                 out_sat_r, out_err_r;

  logic                 load, step_avg, do_mul, do_check, step_div, out_load;
  logic                 avg_last, div_last, slot_free, sat_hit;
  logic [CNT_BITS:0]    tsh, rsh;
  logic                 tge, rge;
  logic [SUM_BITS:0]    qsh;
  logic                 qge;
  logic [SUM_BITS-1:0]  prod_hi;

  assign avg_last  = (step_r == STEP_BITS'(SUM_BITS - 1));
  assign div_last  = (step_r == STEP_BITS'(OUT_BITS - 1));
  assign slot_free = !out_valid_r || pop;

  // restoring division steps
  assign tsh = {trem_r, tq_r[SUM_BITS-1]};
  assign rsh = {rrem_r, rq_r[SUM_BITS-1]};
  assign tge = (tsh >= {1'b0, n_r});
  assign rge = (rsh >= {1'b0, n_r});
  assign qsh = {qrem_r, qq_r[OUT_BITS-1]};
  assign qge = (qsh >= {1'b0, rq_r});

  assign prod_hi = SUM_BITS'(prod_r[PROD_BITS-1:OUT_BITS]);
  assign sat_hit = (prod_hi >= rq_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (job.avail) state_nxt = ST_AVG;
      ST_AVG:   if (avg_last) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (rq_r == '0 || sat_hit) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (div_last) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    step_avg = 1'b0;
    do_mul   = 1'b0;
    do_check = 1'b0;
    step_div = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  load     = job.avail;
      ST_AVG:   step_avg = 1'b1;
      ST_MUL:   do_mul   = 1'b1;
      ST_CHECK: do_check = 1'b1;
      ST_DIV:   step_div = 1'b1;
      ST_DONE:  out_load = slot_free;
      default:  load     = 1'b0;
    endcase
  end

  assign job_pop = load;

  always_ff @(posedge clk) begin
    if (load) begin
      tq_r   <= job.job.target_sum;
      rq_r   <= job.job.ref_sum;
      n_r    <= job.job.n;
      vcal_r <= job.job.vcal;
      trem_r <= '0;
      rrem_r <= '0;
      step_r <= '0;
    end
    if (step_avg) begin
      tq_r   <= {tq_r[SUM_BITS-2:0], tge};
      rq_r   <= {rq_r[SUM_BITS-2:0], rge};
      trem_r <= tge ? CNT_BITS'(tsh - {1'b0, n_r}) : tsh[CNT_BITS-1:0];
      rrem_r <= rge ? CNT_BITS'(rsh - {1'b0, n_r}) : rsh[CNT_BITS-1:0];
      step_r <= step_r + STEP_BITS'(1);
    end
    if (do_mul) begin
      prod_r <= PROD_BITS'(tq_r) * PROD_BITS'(vcal_r);
    end
    if (do_check) begin
      qrem_r    <= prod_hi;
      qq_r      <= prod_r[OUT_BITS-1:0];
      step_r    <= '0;
      res_err_r <= (rq_r == '0);
      res_sat_r <= (rq_r != '0) && sat_hit;
      res_val_r <= (rq_r == '0) ? '0 : '1;
    end
    if (step_div) begin
      qq_r      <= {qq_r[OUT_BITS-2:0], qge};
      qrem_r    <= qge ? SUM_BITS'(qsh - {1'b0, rq_r}) : qsh[SUM_BITS-1:0];
      step_r    <= step_r + STEP_BITS'(1);
      res_val_r <= {qq_r[OUT_BITS-2:0], qge};
    end
    if (out_load) begin
      out_val_r <= res_val_r;
      out_sat_r <= res_sat_r;
      out_err_r <= res_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty           = !out_valid_r;
  assign corrected_value = out_val_r;
  assign saturated       = out_sat_r;
  assign ref_zero_error  = out_err_r;

endmodule

@@ rtl/core/oversampled_adc_vref_corrector.sv @@
// Top level of the oversampled ADC reference corrector: configuration registers and wiring.
//
// Each accepted word is one pair of codes (measured channel, internal reference). Every
// pair, also one that closes a block, is taken while the job queue is not full. The pair
// that closes a block of oversample_count pairs hands both sums to the arithmetic back
// end, which per result takes the job from the queue, runs the two bit-serial averaging
// dividers side by side, does the calibration multiply and the zero and overflow check,
// runs the bit-serial corrected division and loads the result word. A zero reference
// average or an overflow skips the division. The back end holds a finished result while
// a result word is still held. Up to two finished blocks wait in the job queue, so input
// keeps flowing while the back end works; full rises only when that queue holds two jobs.
// A zero oversample_count acts as one. A zero reference average gives value 0 with
// ref_zero_error set; a quotient above 65535 is clamped and flagged as saturated.
module oversampled_adc_vref_corrector import ovc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [SAMPLE_BITS-1:0]  in_target_sample,
  input  logic [SAMPLE_BITS-1:0]  in_vref_sample,
  output logic                    empty,
  input  logic                    pop,
  output logic [OUT_BITS-1:0]     out_corrected_value,
  output logic                    out_saturated,
  output logic                    out_ref_zero_error,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  logic [CNT_BITS-1:0]  oversample_count_r;
  logic [VCAL_BITS-1:0] vref_cal_r;
  logic                 job_full, job_push, job_pop;
  job_t                 job_wdata;
  job_rd_t              job_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oversample_count_r <= OVS_RESET;
      vref_cal_r         <= VCAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_OVERSAMPLE: oversample_count_r <= cfg_data[CNT_BITS-1:0];
        REG_VREF_CAL:   vref_cal_r         <= cfg_data[VCAL_BITS-1:0];
        default:        vref_cal_r         <= vref_cal_r;
      endcase
    end
  end

  ovc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .target_sample    (in_target_sample),
    .vref_sample      (in_vref_sample),
    .oversample_count (oversample_count_r),
    .vref_cal         (vref_cal_r),
    .job_full         (job_full),
    .job_push         (job_push),
    .job_wdata        (job_wdata)
  );

  ovc_job_fifo u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .wr_full (job_full),
    .rd_en   (job_pop),
    .rd      (job_rd)
  );

  ovc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (job_rd),
    .job_pop         (job_pop),
    .empty           (empty),
    .pop             (pop),
    .corrected_value (out_corrected_value),
    .saturated       (out_saturated),
    .ref_zero_error  (out_ref_zero_error)
  );

endmodule

@@ rtl/core/ovc_checker.sv @@
// Port-level checks of the oversampled ADC reference corrector, bound to the top level.
module ovc_checker import ovc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    empty,
  input logic                    pop,
  input logic [OUT_BITS-1:0]     out_corrected_value,
  input logic                    out_saturated,
  input logic                    out_ref_zero_error
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_corrected_value)
      && $stable(out_saturated) && $stable(out_ref_zero_error)))
    else $error("waiting result word changed");

  a_zero_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_ref_zero_error) |-> (out_corrected_value == '0 && !out_saturated))
    else $error("zero reference result malformed");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_saturated) |-> (out_corrected_value == '1))
    else $error("saturated result not clamped");

endmodule

bind oversampled_adc_vref_corrector ovc_checker u_ovc_checker (.*);

@@ sim/oversampled_adc_vref_corrector_tb.sv @@
// Self-checking testbench of the oversampled ADC reference corrector.
module oversampled_adc_vref_corrector_tb import ovc_pkg::*;;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int RUN_LIMIT     = 24_000_000;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                sat;
    logic                ref_zero;
  } corr_word_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic [SAMPLE_BITS-1:0]  in_target_sample = '0;
  logic [SAMPLE_BITS-1:0]  in_vref_sample = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [OUT_BITS-1:0]     out_corrected_value;
  logic                    out_saturated;
  logic                    out_ref_zero_error;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_OVERSAMPLE;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  // predictor state
  logic [CNT_BITS-1:0]  reg_count = OVS_RESET;
  logic [VCAL_BITS-1:0] reg_vcal = VCAL_RESET;
  logic [SUM_BITS-1:0]  acc_target = '0;
  logic [SUM_BITS-1:0]  acc_ref = '0;
  logic [CNT_BITS-1:0]  acc_pairs = '0;
  corr_word_t           pending_codes[$];

  int  fails = 0;
  bit  tx_no_idle = 1'b0;
  bit  rx_no_idle = 1'b0;
  int  rx_gap = 0;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  oversampled_adc_vref_corrector dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_target_sample    (in_target_sample),
    .in_vref_sample      (in_vref_sample),
    .empty               (empty),
    .pop                 (pop),
    .out_corrected_value (out_corrected_value),
    .out_saturated       (out_saturated),
    .out_ref_zero_error  (out_ref_zero_error),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // accumulate one pair; queue the corrected word when a block closes
  function automatic void fold_pair(logic [SAMPLE_BITS-1:0] t, logic [SAMPLE_BITS-1:0] r);
    logic [CNT_BITS-1:0] n;
    logic [63:0]         avg_t;
    logic [63:0]         avg_r;
    logic [63:0]         q;
    corr_word_t          w;
    n = (reg_count == '0) ? CNT_BITS'(1) : reg_count;
    acc_target = acc_target + SUM_BITS'(t);
    acc_ref    = acc_ref + SUM_BITS'(r);
    acc_pairs  = acc_pairs + CNT_BITS'(1);
    if (acc_pairs < n) return;
    avg_t = 64'(acc_target) / 64'(n);
    avg_r = 64'(acc_ref) / 64'(n);
    if (avg_r == 0) begin
      w = '{value: '0, sat: 1'b0, ref_zero: 1'b1};
    end else begin
      q = (avg_t * 64'(reg_vcal)) / avg_r;
      if (q > 64'hFFFF) w = '{value: '1, sat: 1'b1, ref_zero: 1'b0};
      else w = '{value: q[OUT_BITS-1:0], sat: 1'b0, ref_zero: 1'b0};
    end
    pending_codes.push_back(w);
    acc_target = '0;
    acc_ref    = '0;
    acc_pairs  = '0;
  endfunction

  function automatic void check_word();
    corr_word_t w;
    if (pending_codes.size() == 0) begin
      $error("unexpected word: corrected_value %0d saturated %0b ref_zero_error %0b",
             out_corrected_value, out_saturated, out_ref_zero_error);
      fails++;
      return;
    end
    w = pending_codes.pop_front();
    if (out_corrected_value !== w.value) begin
      $error("corrected_value: expected %0d, got %0d", w.value, out_corrected_value);
      fails++;
    end
    if (out_saturated !== w.sat) begin
      $error("saturated: expected %0b, got %0b", w.sat, out_saturated);
      fails++;
    end
    if (out_ref_zero_error !== w.ref_zero) begin
      $error("ref_zero_error: expected %0b, got %0b", w.ref_zero, out_ref_zero_error);
      fails++;
    end
  endfunction

  // receiver: checks each word, random gaps, long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_word();
        rx_gap = rx_no_idle ? 0 : $urandom_range(0, 16);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      pop <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  task automatic send_pair(input logic [SAMPLE_BITS-1:0] t, input logic [SAMPLE_BITS-1:0] r);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push             <= 1'b1;
    in_target_sample <= t;
    in_vref_sample   <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    fold_pair(t, r);
  endtask

  // back end idle: every word out, then room for a job still in flight
  task automatic settle();
    push <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_OVERSAMPLE) reg_count = d;
    else reg_vcal = d[VCAL_BITS-1:0];
  endtask

  task automatic test_reset_values();
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd4095, 12'd1);
    send_pair(12'd0, 12'd4095);
    send_pair(12'd2730, 12'd1365);
    settle();
  endtask

  task automatic test_zero_count();
    write_reg(REG_OVERSAMPLE, 16'd0);
    write_reg(REG_VREF_CAL, 16'hF000 | 16'd4095);
    send_pair(12'd4095, 12'd1);
    send_pair(12'd1, 12'd4095);
    send_pair(12'd4095, 12'd4095);
    settle();
  endtask

  task automatic test_averaging();
    write_reg(REG_OVERSAMPLE, 16'd4);
    write_reg(REG_VREF_CAL, 16'd0);
    send_pair(12'd4095, 12'd100);
    send_pair(12'd17, 12'd3);
    send_pair(12'd2048, 12'd77);
    send_pair(12'd1, 12'd9);
    settle();
    // reference sum below the count: average truncates to zero
    write_reg(REG_OVERSAMPLE, 16'd3);
    write_reg(REG_VREF_CAL, 16'd2048);
    send_pair(12'd5, 12'd1);
    send_pair(12'd6, 12'd1);
    send_pair(12'd7, 12'd0);
    settle();
    write_reg(REG_OVERSAMPLE, 16'd2);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd4094, 12'd4094);
    settle();
  endtask

  // count lowered below the pairs already taken
  task automatic test_count_lowered();
    write_reg(REG_OVERSAMPLE, 16'd10);
    write_reg(REG_VREF_CAL, 16'd1489);
    repeat (6) send_pair(12'($urandom_range(0, 4095)), 12'($urandom_range(1, 4095)));
    settle();
    write_reg(REG_OVERSAMPLE, 16'd3);
    send_pair(12'd4095, 12'd2000);
    settle();
  endtask

  task automatic test_random();
    int sel;
    logic [CNT_BITS-1:0]  cnt;
    logic [VCAL_BITS-1:0] vcal;
    logic [SAMPLE_BITS-1:0] t;
    logic [SAMPLE_BITS-1:0] r;
    for (int ph = 0; ph < 12; ph++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) cnt = '0;
      else if (sel == 1) cnt = CNT_BITS'($urandom_range(9, 40));
      else cnt = CNT_BITS'($urandom_range(1, 8));
      sel = $urandom_range(0, 7);
      if (sel == 0) vcal = '0;
      else if (sel == 1) vcal = '1;
      else vcal = VCAL_BITS'($urandom_range(0, 4095));
      if (ph % 2 == 0) begin
        write_reg(REG_OVERSAMPLE, cnt);
        write_reg(REG_VREF_CAL, {4'($urandom_range(0, 15)), vcal});
      end else begin
        write_reg(REG_VREF_CAL, {4'($urandom_range(0, 15)), vcal});
        write_reg(REG_OVERSAMPLE, cnt);
      end
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 150; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) t = '1;
        else if (sel == 1) t = '0;
        else t = SAMPLE_BITS'($urandom_range(0, 4095));
        sel = $urandom_range(0, 9);
        if (sel == 0) r = SAMPLE_BITS'($urandom_range(0, 3));
        else if (sel == 1) r = '1;
        else r = SAMPLE_BITS'($urandom_range(0, 4095));
        send_pair(t, r);
      end
      settle();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // receiver stops for a long stretch while pairs keep coming
  task automatic test_backpressure();
    write_reg(REG_OVERSAMPLE, 16'd1);
    write_reg(REG_VREF_CAL, 16'd1489);
    tx_no_idle = 1'b1;
    hold_seq++;
    for (int i = 0; i < 40; i++)
      send_pair(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    tx_no_idle = 1'b0;
    settle();
  endtask

  // largest count, then lowered so the next pair closes a wide block
  task automatic test_max_count();
    write_reg(REG_OVERSAMPLE, 16'hFFFF);
    write_reg(REG_VREF_CAL, 16'($urandom_range(0, 4095)));
    tx_no_idle = 1'b1;
    for (int i = 0; i < 40; i++)
      send_pair(($urandom_range(0, 1) == 0) ? 12'd4095 : 12'($urandom_range(0, 4095)),
                ($urandom_range(0, 1) == 0) ? 12'd4095 : 12'($urandom_range(0, 4095)));
    tx_no_idle = 1'b0;
    settle();
    write_reg(REG_OVERSAMPLE, 16'd20);
    send_pair(12'd4095, 12'd4095);
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_zero_count();
    test_averaging();
    test_count_lowered();
    test_random();
    test_backpressure();
    test_max_count();
    if (fails == 0 && pending_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
